[src/mrr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrr_pkg: shared types and constants of the matrix ring rotation core
// Holds the command format passed from the front end to the back end, the
// configuration bundle, register indexes and operation codes.
// ----------------------------------------------------------------------------
package mrr_pkg;

    // default sizes of the element store
    localparam int DEF_MAX_ROWS   = 256;
    localparam int DEF_MAX_COLS   = 256;
    localparam int DEF_DATA_WIDTH = 32;

    // fixed field widths
    localparam int COORD_W   = 9;   // row/col counts and ring coordinates
    localparam int IN_POS_W  = 8;   // row/col of an input beat
    localparam int LEN_W     = 11;  // ring length and walk position
    localparam int VALUE_W   = 32;
    localparam int STEP_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int COORD_MAX = (1 << COORD_W) - 1;

    localparam logic [COORD_W-1:0] COORD_ONE = COORD_W'(1);
    localparam logic [COORD_W-1:0] MIN_SIZE  = COORD_W'(2);

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ROTATE_STEPS = CFG_IDX_W'(2);

    // reset values of the registers
    localparam logic [COORD_W-1:0] ROW_COUNT_RST    = COORD_W'(2);
    localparam logic [COORD_W-1:0] COL_COUNT_RST    = COORD_W'(2);
    localparam logic [STEP_W-1:0]  ROTATE_STEPS_RST = '0;

    // input operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // entries of the command queue
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_READ_DIRECT,
        CMD_READ_ZERO,
        CMD_READ_RING
    } cmd_kind_t;

    typedef struct packed {
        logic [COORD_W-1:0] row_count;
        logic [COORD_W-1:0] col_count;
        logic [STEP_W-1:0]  rotate_steps;
    } cfg_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [COORD_W-1:0]  row;
        logic [COORD_W-1:0]  col;
        logic [VALUE_W-1:0]  value;
        logic [LEN_W-1:0]    pos;     // walk position of the queried cell
        logic [LEN_W-1:0]    len;     // ring length
        logic [COORD_W-1:0]  top;     // also the left edge of the ring
        logic [COORD_W-1:0]  bottom;
        logic [COORD_W-1:0]  right;
        logic [COORD_W-1:0]  h;       // rows minus one
        logic [COORD_W-1:0]  w;       // columns minus one
    } cmd_t;

    typedef struct packed {
        logic idle;
        logic dividing;
    } back_stat_t;

endpackage

[src/matrix_ring_rotation_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_ring_rotation_core: stored matrix read back with rotated rings
// Stores matrix elements and answers reads as if every concentric ring were
// rotated counterclockwise by a configured number of steps.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (s_valid/s_ready) carry an op, a row, a column and a value.
//   A write beat gives no result and stores its value if in the store; a read
//   beat gives exactly one result beat on m_valid/m_ready, in input order.
//   row_count, col_count and rotate_steps are set on the cfg_* write port
//   while the core is idle; a write takes effect at the next edge.
// Command flow:
//   The front end classifies a beat in its stage A and stage B registers
//   and hands it through a 2-entry command queue to the back end. A write
//   is done in the cycle it is popped. A read of a rotated ring passes
//   through the pop, ST_DIV, which reduces the step count modulo the ring
//   length one bit per cycle, ST_MAP and ST_LOC, which map the walk
//   position to a cell, and ST_READ and ST_DONE, which read the store. A
//   direct read passes through ST_READ and ST_DONE, a read outside the
//   store only ST_DONE. The back end takes no new command until it is idle.
// Reset and stalls:
//   aresetn (synchronous, active low) empties the pipeline and queue and
//   restores the registers; stored elements are not cleared. A stalled
//   receiver holds the result in the output register; the front end and the
//   queue keep taking beats until they fill, then s_ready drops.
// ----------------------------------------------------------------------------
module matrix_ring_rotation_core #(
    parameter int MAX_ROWS   = mrr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS   = mrr_pkg::DEF_MAX_COLS,
    parameter int DATA_WIDTH = mrr_pkg::DEF_DATA_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [mrr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mrr_pkg::STEP_W-1:0]          cfg_wdata,
    // input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_op,
    input  logic [mrr_pkg::IN_POS_W-1:0]        s_row,
    input  logic [mrr_pkg::IN_POS_W-1:0]        s_col,
    input  logic signed [mrr_pkg::VALUE_W-1:0]  s_value,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [mrr_pkg::VALUE_W-1:0]  m_rotated_value
);

    mrr_pkg::cfg_t       cfg_reg;
    mrr_pkg::back_stat_t back_stat;

    // front end -> queue
    logic                q_push_valid;
    logic                q_push_ready;
    mrr_pkg::cmd_t       q_push_data;
    // queue -> back end
    logic                q_pop_valid;
    logic                q_pop_ready;
    mrr_pkg::cmd_t       q_head;

    // Register file: take the low bits of the write data, drop unknown
    // indexes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.row_count    <= mrr_pkg::ROW_COUNT_RST;
            cfg_reg.col_count    <= mrr_pkg::COL_COUNT_RST;
            cfg_reg.rotate_steps <= mrr_pkg::ROTATE_STEPS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mrr_pkg::REG_ROW_COUNT: begin
                    cfg_reg.row_count <= cfg_wdata[mrr_pkg::COORD_W-1:0];
                end
                mrr_pkg::REG_COL_COUNT: begin
                    cfg_reg.col_count <= cfg_wdata[mrr_pkg::COORD_W-1:0];
                end
                mrr_pkg::REG_ROTATE_STEPS: begin
                    cfg_reg.rotate_steps <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // Classify each beat: write, direct read, out-of-store read, ring read.
    mrr_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_op),
        .s_row     (s_row),
        .s_col     (s_col),
        .s_value   (s_value),
        .cmd_valid (q_push_valid),
        .cmd_ready (q_push_ready),
        .cmd_data  (q_push_data)
    );

    // Decouple classification from the long ring reads.
    mrr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_head)
    );

    // Execute commands in order against the element store.
    mrr_back #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .cmd_valid       (q_pop_valid),
        .cmd_ready       (q_pop_ready),
        .cmd_data        (q_head),
        .stat            (back_stat),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_rotated_value (m_rotated_value)
    );

`ifndef SYNTH
    // a ring read popped from the queue starts the remainder unit next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop_valid && q_pop_ready && (q_head.kind == mrr_pkg::CMD_READ_RING))
        |=> back_stat.dividing)
        else $error("ring read did not enter the remainder unit");

    // a write finishes in the cycle it is popped
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop_valid && q_pop_ready && (q_head.kind == mrr_pkg::CMD_WRITE))
        |=> back_stat.idle)
        else $error("write left the back end busy");

    // reset empties the output register
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");
`endif

endmodule

[src/mrr_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrr_front: input classifier
// Two-stage pipeline: finds the ring of the addressed cell, then its ring
// geometry and walk position, and emits one command per surviving beat.
// ----------------------------------------------------------------------------
module mrr_front #(
    parameter int MAX_ROWS = mrr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = mrr_pkg::DEF_MAX_COLS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mrr_pkg::cfg_t                       cfg,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_op,
    input  logic [mrr_pkg::IN_POS_W-1:0]        s_row,
    input  logic [mrr_pkg::IN_POS_W-1:0]        s_col,
    input  logic signed [mrr_pkg::VALUE_W-1:0]  s_value,
    output logic                                cmd_valid,
    input  logic                                cmd_ready,
    output mrr_pkg::cmd_t                       cmd_data
);

    localparam int CW = mrr_pkg::COORD_W;
    localparam int LW = mrr_pkg::LEN_W;

    localparam logic [CW-1:0] ROW_CAP =
        (MAX_ROWS > mrr_pkg::COORD_MAX) ? CW'(mrr_pkg::COORD_MAX) : CW'(MAX_ROWS);
    localparam logic [CW-1:0] COL_CAP =
        (MAX_COLS > mrr_pkg::COORD_MAX) ? CW'(mrr_pkg::COORD_MAX) : CW'(MAX_COLS);

    typedef struct packed {
        logic                             op;
        logic [CW-1:0]                    row;
        logic [CW-1:0]                    col;
        logic [mrr_pkg::VALUE_W-1:0]      value;
        logic                             outside;
        logic                             in_store;
        logic [CW-1:0]                    p;
    } stage_a_t;

    function automatic logic [CW-1:0] clamp_size(input logic [CW-1:0] v,
                                                 input logic [CW-1:0] cap);
        logic [CW-1:0] res;
        res = v;
        if (v < mrr_pkg::MIN_SIZE) begin
            res = mrr_pkg::MIN_SIZE;
        end else if (v > cap) begin
            res = cap;
        end
        return res;
    endfunction

    function automatic logic [CW-1:0] min2(input logic [CW-1:0] x, input logic [CW-1:0] y);
        return (x < y) ? x : y;
    endfunction

    logic [CW-1:0] nr;
    logic [CW-1:0] nc;
    logic [CW-1:0] in_r;
    logic [CW-1:0] in_c;
    logic [CW-1:0] dist_bot;
    logic [CW-1:0] dist_right;

    stage_a_t      a_reg;
    stage_a_t      a_next;
    logic          a_valid_reg;
    logic          a_ready;

    mrr_pkg::cmd_t b_cmd_reg;
    mrr_pkg::cmd_t b_cmd_next;
    logic          b_valid_reg;
    logic          b_valid_next;
    logic          b_ready;

    // stage B geometry
    logic [CW-1:0] rings;
    logic          moving;
    logic [CW-1:0] bottom;
    logic [CW-1:0] right;
    logic [CW-1:0] h;
    logic [CW-1:0] w;
    logic [LW-1:0] h_l;
    logic [LW-1:0] w_l;
    logic [LW-1:0] hw_l;
    logic [LW-1:0] r_l;
    logic [LW-1:0] c_l;
    logic [LW-1:0] p_l;
    logic [LW-1:0] bottom_l;
    logic [LW-1:0] right_l;
    logic [LW-1:0] pos;

    assign nr = clamp_size(cfg.row_count, ROW_CAP);
    assign nc = clamp_size(cfg.col_count, COL_CAP);

    // stage A: ring index from the distance to the nearest edge
    always_comb begin
        in_r       = CW'(s_row);
        in_c       = CW'(s_col);
        dist_bot   = nr - mrr_pkg::COORD_ONE - in_r;
        dist_right = nc - mrr_pkg::COORD_ONE - in_c;
        a_next.op       = s_op;
        a_next.row      = in_r;
        a_next.col      = in_c;
        a_next.value    = s_value;
        a_next.outside  = (in_r >= nr) || (in_c >= nc);
        a_next.in_store = (32'(in_r) < 32'(MAX_ROWS)) && (32'(in_c) < 32'(MAX_COLS));
        a_next.p        = min2(min2(in_r, in_c), min2(dist_bot, dist_right));
    end

    // stage B: ring geometry and walk position
    always_comb begin
        rings    = min2(nr, nc) >> 1;
        moving   = !a_reg.outside && (a_reg.p < rings);
        bottom   = nr - mrr_pkg::COORD_ONE - a_reg.p;
        right    = nc - mrr_pkg::COORD_ONE - a_reg.p;
        h        = bottom - a_reg.p;
        w        = right - a_reg.p;
        h_l      = LW'(h);
        w_l      = LW'(w);
        hw_l     = h_l + w_l;
        r_l      = LW'(a_reg.row);
        c_l      = LW'(a_reg.col);
        p_l      = LW'(a_reg.p);
        bottom_l = LW'(bottom);
        right_l  = LW'(right);

        if (a_reg.col == a_reg.p && a_reg.row < bottom) begin
            pos = r_l - p_l;
        end else if (a_reg.row == bottom && a_reg.col < right) begin
            pos = h_l + (c_l - p_l);
        end else if (a_reg.col == right && a_reg.row > a_reg.p) begin
            pos = hw_l + (bottom_l - r_l);
        end else begin
            pos = hw_l + h_l + (right_l - c_l);
        end

        b_cmd_next.row    = a_reg.row;
        b_cmd_next.col    = a_reg.col;
        b_cmd_next.value  = a_reg.value;
        b_cmd_next.pos    = pos;
        b_cmd_next.len    = hw_l + hw_l;
        b_cmd_next.top    = a_reg.p;
        b_cmd_next.bottom = bottom;
        b_cmd_next.right  = right;
        b_cmd_next.h      = h;
        b_cmd_next.w      = w;

        // drop writes outside the store
        b_valid_next = a_valid_reg;
        if (a_reg.op == mrr_pkg::OP_WRITE) begin
            b_cmd_next.kind = mrr_pkg::CMD_WRITE;
            b_valid_next    = a_valid_reg && a_reg.in_store;
        end else if (moving) begin
            b_cmd_next.kind = mrr_pkg::CMD_READ_RING;
        end else if (a_reg.in_store) begin
            b_cmd_next.kind = mrr_pkg::CMD_READ_DIRECT;
        end else begin
            b_cmd_next.kind = mrr_pkg::CMD_READ_ZERO;
        end
    end

    assign b_ready   = !b_valid_reg || cmd_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign s_ready   = a_ready;
    assign cmd_valid = b_valid_reg;
    assign cmd_data  = b_cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= s_valid;
            end
            if (b_ready) begin
                b_valid_reg <= b_valid_next;
            end
        end
        if (a_ready) begin
            a_reg <= a_next;
        end
        if (b_ready) begin
            b_cmd_reg <= b_cmd_next;
        end
    end

endmodule

[src/mrr_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrr_queue: command queue
// Small FIFO between the classifier and the executor.
// ----------------------------------------------------------------------------
module mrr_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  mrr_pkg::cmd_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output mrr_pkg::cmd_t pop_data
);

    localparam int DEPTH = mrr_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    mrr_pkg::cmd_t  slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [NW-1:0]  count_reg;
    logic [NW-1:0]  count_next;
    logic           push;
    logic           pop;

    assign push_ready = (count_reg != NW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + NW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[src/mrr_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrr_back: command executor
// Owns the element store. Writes finish when taken; ring reads reduce the step
// count modulo the ring length bit-serially, map back to a source cell, read.
// ----------------------------------------------------------------------------
module mrr_back #(
    parameter int MAX_ROWS   = mrr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS   = mrr_pkg::DEF_MAX_COLS,
    parameter int DATA_WIDTH = mrr_pkg::DEF_DATA_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mrr_pkg::cfg_t                       cfg,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  mrr_pkg::cmd_t                       cmd_data,
    output mrr_pkg::back_stat_t                 stat,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [mrr_pkg::VALUE_W-1:0]  m_rotated_value
);

    localparam int CW        = mrr_pkg::COORD_W;
    localparam int LW        = mrr_pkg::LEN_W;
    localparam int SW        = mrr_pkg::STEP_W;
    localparam int VW        = mrr_pkg::VALUE_W;
    localparam int CNT_W     = $clog2(SW);
    localparam int ROW_AW    = $clog2(MAX_ROWS);
    localparam int COL_AW    = $clog2(MAX_COLS);
    localparam int ADDR_W    = ROW_AW + COL_AW;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MAP,
        ST_LOC,
        ST_READ,
        ST_DONE
    } state_t;

    function automatic logic [ADDR_W-1:0] store_addr(input logic [CW-1:0] r,
                                                     input logic [CW-1:0] c);
        return {ROW_AW'(r), COL_AW'(c)};
    endfunction

    logic [DATA_WIDTH-1:0] mem [MEM_DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    state_t             state_reg;
    state_t             state_next;
    mrr_pkg::cmd_t      cmd_reg;
    mrr_pkg::cmd_t      cmd_next;
    logic [LW-1:0]      rem_reg;
    logic [LW-1:0]      rem_next;
    logic [SW-1:0]      steps_sh_reg;
    logic [SW-1:0]      steps_sh_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [LW-1:0]      src_reg;
    logic [LW-1:0]      src_next;
    logic [ADDR_W-1:0]  rd_addr_reg;
    logic [ADDR_W-1:0]  rd_addr_next;
    logic               zero_reg;
    logic               zero_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [VW-1:0]      out_data_reg;
    logic [VW-1:0]      out_data_next;

    logic               mem_we;
    logic [LW:0]        trial;
    logic [LW:0]        wrap;
    logic [LW-1:0]      top_l;
    logic [LW-1:0]      bottom_l;
    logic [LW-1:0]      right_l;
    logic [LW-1:0]      h_l;
    logic [LW-1:0]      hw_l;
    logic [LW-1:0]      hhw_l;
    logic [CW-1:0]      src_r;
    logic [CW-1:0]      src_c;

    assign cmd_ready       = (state_reg == ST_IDLE);
    assign mem_we          = cmd_ready && cmd_valid && (cmd_data.kind == mrr_pkg::CMD_WRITE);
    assign stat.idle       = (state_reg == ST_IDLE);
    assign stat.dividing   = (state_reg == ST_DIV);
    assign m_valid         = out_valid_reg;
    assign m_rotated_value = out_data_reg;

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        rem_next       = rem_reg;
        steps_sh_next  = steps_sh_reg;
        cnt_next       = cnt_reg;
        src_next       = src_reg;
        rd_addr_next   = rd_addr_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;

        trial    = {rem_reg, steps_sh_reg[SW-1]};
        wrap     = {1'b0, cmd_reg.pos} + {1'b0, cmd_reg.len} - {1'b0, rem_reg};
        top_l    = LW'(cmd_reg.top);
        bottom_l = LW'(cmd_reg.bottom);
        right_l  = LW'(cmd_reg.right);
        h_l      = LW'(cmd_reg.h);
        hw_l     = h_l + LW'(cmd_reg.w);
        hhw_l    = hw_l + h_l;

        // walk position back to a cell: left side, bottom, right side, top
        if (src_reg < h_l) begin
            src_r = CW'(top_l + src_reg);
            src_c = cmd_reg.top;
        end else if (src_reg < hw_l) begin
            src_r = cmd_reg.bottom;
            src_c = CW'(top_l + (src_reg - h_l));
        end else if (src_reg < hhw_l) begin
            src_r = CW'(bottom_l - (src_reg - hw_l));
            src_c = cmd_reg.right;
        end else begin
            src_r = cmd_reg.top;
            src_c = CW'(right_l - (src_reg - hhw_l));
        end

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_next = cmd_data;
                    case (cmd_data.kind)
                        mrr_pkg::CMD_READ_ZERO: begin
                            zero_next  = 1'b1;
                            state_next = ST_DONE;
                        end
                        mrr_pkg::CMD_READ_DIRECT: begin
                            zero_next    = 1'b0;
                            rd_addr_next = store_addr(cmd_data.row, cmd_data.col);
                            state_next   = ST_READ;
                        end
                        mrr_pkg::CMD_READ_RING: begin
                            rem_next      = '0;
                            steps_sh_next = cfg.rotate_steps;
                            cnt_next      = '0;
                            state_next    = ST_DIV;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                // one restoring remainder step per cycle, MSB first
                rem_next      = (trial >= {1'b0, cmd_reg.len}) ?
                                LW'(trial - {1'b0, cmd_reg.len}) : LW'(trial);
                steps_sh_next = steps_sh_reg << 1;
                cnt_next      = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SW - 1)) begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP: begin
                src_next   = (cmd_reg.pos >= rem_reg) ? (cmd_reg.pos - rem_reg) : LW'(wrap);
                state_next = ST_LOC;
            end
            ST_LOC: begin
                zero_next    = 1'b0;
                rd_addr_next = store_addr(src_r, src_c);
                state_next   = ST_READ;
            end
            ST_READ: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = zero_reg ? '0 : VW'(rd_data_reg);
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        cmd_reg      <= cmd_next;
        rem_reg      <= rem_next;
        steps_sh_reg <= steps_sh_next;
        cnt_reg      <= cnt_next;
        src_reg      <= src_next;
        rd_addr_reg  <= rd_addr_next;
        zero_reg     <= zero_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[store_addr(cmd_data.row, cmd_data.col)] <= DATA_WIDTH'(signed'(cmd_data.value));
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr_reg];
    end

endmodule
